/* rtl/mbp_pkg.sv */
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants for the Modbus BMS response parser.
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int MAX_BYTE_COUNT_DEF = 68;
  localparam int DECODED_BYTES      = 66;
  localparam int CELL_COUNT         = 16;
  localparam int TEMP_COUNT         = 3;
  localparam int NUM_FIELDS         = CELL_COUNT + TEMP_COUNT + 10;

  localparam int RX_BYTE_W     = 8;
  localparam int FIELD_INDEX_W = 5;
  localparam int FIELD_VALUE_W = 32;
  localparam int GOOD_FRAMES_W = 16;
  localparam int OFF_W         = $clog2(DECODED_BYTES + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_SLAVE_ADDRESS      = 2'd0,
    REG_READ_FUNCTION_CODE = 2'd1,
    REG_CRC_CHECK_ENABLE   = 2'd2
  } reg_index_t;

  typedef enum logic [0:0] {
    OP_BYTE = 1'b0,
    OP_GAP  = 1'b1
  } opcode_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

endpackage

/* rtl/mbp_stream_if.sv */
// ----------------------------------------------------------------------------
// mbp_stream_if
// Valid/ready channels: received byte stream and decoded field stream.
// ----------------------------------------------------------------------------
interface mbp_byte_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [mbp_pkg::RX_BYTE_W-1:0]  rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface mbp_field_if;
  logic                               valid;
  logic                               ready;
  logic [mbp_pkg::FIELD_INDEX_W-1:0]  field_index;
  logic [mbp_pkg::FIELD_VALUE_W-1:0]  field_value;
  logic                               frame_status;
  logic [mbp_pkg::GOOD_FRAMES_W-1:0]  good_frames;
  logic                               last;

  modport source (output valid, output field_index, output field_value,
                  output frame_status, output good_frames, output last,
                  input ready);
  modport sink   (input valid, input field_index, input field_value,
                  input frame_status, input good_frames, input last,
                  output ready);
endinterface

/* rtl/mbp_ram.sv */
// ----------------------------------------------------------------------------
// mbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 68
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/modbus_bms_response_parser.sv */
// ----------------------------------------------------------------------------
// modbus_bms_response_parser
// Hunts for a Modbus RTU read response and emits the decoded BMS fields.
// ----------------------------------------------------------------------------
// Each input item is a received byte or a line-idle gap. Address, function,
// count and payload bytes that the parser keeps are accepted and then run
// through the bit-serial CRC-16 unit, which holds input off. Gaps, discarded
// bytes and the two CRC bytes are only accepted. The final CRC byte starts the
// field unpacker, which reads the payload RAM one byte at a time via a fetch
// and an accumulate state and loads one result per field (29 from 66 bytes,
// one on a CRC error); input waits for it and any output stall. Registers sit
// on APB at byte addresses 0, 4 and 8 and must be written while idle.
// ----------------------------------------------------------------------------
module modbus_bms_response_parser #(
  parameter int MAX_BYTE_COUNT = mbp_pkg::MAX_BYTE_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  mbp_byte_if.sink                     byte_stream,
  mbp_field_if.source                  field_stream,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbp_pkg::PADDR_W-1:0]  paddr,
  input  logic [mbp_pkg::PDATA_W-1:0]  pwdata,
  output logic [mbp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int AW    = $clog2(MAX_BYTE_COUNT);
  localparam int LEN_W = $clog2(MAX_BYTE_COUNT + 1);
  localparam int POS_W = $clog2(MAX_BYTE_COUNT + 3);
  localparam int CMP_W = POS_W + 1;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_FUNC    = 5'b00010,
    PH_COUNT   = 5'b00100,
    PH_DATA    = 5'b01000,
    PH_DISCARD = 5'b10000
  } phase_t;

  typedef enum logic [4:0] {
    SQ_IDLE  = 5'b00001,
    SQ_CRC   = 5'b00010,
    SQ_FETCH = 5'b00100,
    SQ_ACC   = 5'b01000,
    SQ_OUT   = 5'b10000
  } seq_t;

  // Registers
  logic [7:0]                          slave_address;
  logic [7:0]                          read_function_code;
  logic                                crc_check_enable;

  phase_t                              phase;
  seq_t                                seq;
  logic [POS_W-1:0]                    byte_position;
  logic [LEN_W-1:0]                    payload_length;
  logic [15:0]                         running_crc;
  logic [15:0]                         tail_bytes;
  logic [mbp_pkg::GOOD_FRAMES_W-1:0]   accepted_count;
  logic [2:0]                          bit_cnt;
  logic                                err;
  logic [mbp_pkg::FIELD_INDEX_W-1:0]   field_k;
  logic [mbp_pkg::OFF_W-1:0]           off;
  logic [2:0]                          byte_cnt;
  logic [mbp_pkg::FIELD_VALUE_W-1:0]   acc;

  logic                                out_valid;
  logic [mbp_pkg::FIELD_INDEX_W-1:0]   out_index;
  logic [mbp_pkg::FIELD_VALUE_W-1:0]   out_value;
  logic                                out_status;
  logic [mbp_pkg::GOOD_FRAMES_W-1:0]   out_good;
  logic                                out_last;

  // Combinational
  logic                                in_accept;
  logic                                cfg_write;
  logic                                ram_we;
  logic [7:0]                          ram_rdata;
  logic [7:0]                          rd_byte;
  logic [15:0]                         tail_new;
  logic                                frame_end;
  logic                                out_free;
  logic                                field_done;
  logic                                is_last_field;
  logic [15:0]                         crc_step;

  function automatic logic [2:0] field_bytes(input logic [mbp_pkg::FIELD_INDEX_W-1:0] k);
    int unsigned kk;
    kk = int'(k);
    if (kk < mbp_pkg::CELL_COUNT) begin
      return 3'd2;
    end else if (kk < mbp_pkg::CELL_COUNT + 2) begin
      return 3'd4;
    end else if (kk < mbp_pkg::CELL_COUNT + 2 + mbp_pkg::TEMP_COUNT) begin
      return 3'd2;
    end else if (kk < mbp_pkg::CELL_COUNT + 4 + mbp_pkg::TEMP_COUNT) begin
      return 3'd4;
    end else begin
      return 3'd2;
    end
  endfunction

  mbp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTE_COUNT)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (byte_position[AW-1:0]),
    .wdata (byte_stream.rx_byte),
    .raddr (AW'(off)),
    .rdata (ram_rdata)
  );

  assign in_accept  = byte_stream.valid && byte_stream.ready;
  assign cfg_write  = psel && penable && pwrite && pready;
  assign pready     = 1'b1;
  assign byte_stream.ready = (seq == SQ_IDLE);

  assign ram_we = in_accept && (byte_stream.opcode == mbp_pkg::OP_BYTE) &&
                  (phase == PH_DATA) &&
                  (CMP_W'(byte_position) < CMP_W'(payload_length));

  assign tail_new  = {byte_stream.rx_byte, tail_bytes[15:8]};
  assign frame_end = (CMP_W'(byte_position) + CMP_W'(1)) >=
                     (CMP_W'(payload_length) + CMP_W'(2));

  assign rd_byte = ((CMP_W'(off) < CMP_W'(payload_length)) &&
                    (int'(off) < mbp_pkg::DECODED_BYTES)) ? ram_rdata : 8'h00;

  assign out_free      = !out_valid || field_stream.ready;
  assign field_done    = (byte_cnt + 3'd1) == field_bytes(field_k);
  assign is_last_field = err || (int'(field_k) == mbp_pkg::NUM_FIELDS - 1);
  assign crc_step      = running_crc[0] ? ((running_crc >> 1) ^ mbp_pkg::CRC_POLY)
                                        : (running_crc >> 1);

  assign field_stream.valid        = out_valid;
  assign field_stream.field_index  = out_index;
  assign field_stream.field_value  = out_value;
  assign field_stream.frame_status = out_status;
  assign field_stream.good_frames  = out_good;
  assign field_stream.last         = out_last;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      mbp_pkg::REG_SLAVE_ADDRESS:      prdata = mbp_pkg::PDATA_W'(slave_address);
      mbp_pkg::REG_READ_FUNCTION_CODE: prdata = mbp_pkg::PDATA_W'(read_function_code);
      mbp_pkg::REG_CRC_CHECK_ENABLE:   prdata = mbp_pkg::PDATA_W'(crc_check_enable);
      default:                         prdata = '0;
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address      <= 8'd1;
      read_function_code <= 8'd3;
      crc_check_enable   <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        mbp_pkg::REG_SLAVE_ADDRESS:      slave_address      <= pwdata[7:0];
        mbp_pkg::REG_READ_FUNCTION_CODE: read_function_code <= pwdata[7:0];
        mbp_pkg::REG_CRC_CHECK_ENABLE:   crc_check_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq == SQ_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (field_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq == SQ_OUT && out_free) begin
      out_index  <= err ? '0 : field_k;
      out_value  <= err ? '0 : acc;
      out_status <= err;
      out_good   <= accepted_count;
      out_last   <= is_last_field;
    end
  end

  // Parser and sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      seq            <= SQ_IDLE;
      byte_position  <= '0;
      payload_length <= '0;
      running_crc    <= mbp_pkg::CRC_INIT;
      tail_bytes     <= '0;
      accepted_count <= '0;
      bit_cnt        <= '0;
      err            <= 1'b0;
      field_k        <= '0;
      off            <= '0;
      byte_cnt       <= '0;
      acc            <= '0;
    end else begin
      unique case (seq)
        SQ_IDLE: begin
          if (in_accept) begin
            bit_cnt <= '0;
            if (byte_stream.opcode == mbp_pkg::OP_GAP) begin
              phase         <= PH_HUNT;
              byte_position <= '0;
              tail_bytes    <= '0;
              running_crc   <= mbp_pkg::CRC_INIT;
            end else begin
              unique case (phase)
                PH_HUNT: begin
                  if (byte_stream.rx_byte == slave_address) begin
                    running_crc   <= mbp_pkg::CRC_INIT ^ {8'h00, byte_stream.rx_byte};
                    byte_position <= '0;
                    tail_bytes    <= '0;
                    phase         <= PH_FUNC;
                    seq           <= SQ_CRC;
                  end else begin
                    phase <= PH_DISCARD;
                  end
                end
                PH_FUNC: begin
                  if (byte_stream.rx_byte == read_function_code) begin
                    running_crc <= running_crc ^ {8'h00, byte_stream.rx_byte};
                    phase       <= PH_COUNT;
                    seq         <= SQ_CRC;
                  end else begin
                    phase <= PH_DISCARD;
                  end
                end
                PH_COUNT: begin
                  if (byte_stream.rx_byte <= 8'(MAX_BYTE_COUNT)) begin
                    running_crc    <= running_crc ^ {8'h00, byte_stream.rx_byte};
                    payload_length <= LEN_W'(byte_stream.rx_byte);
                    byte_position  <= '0;
                    tail_bytes     <= '0;
                    phase          <= PH_DATA;
                    seq            <= SQ_CRC;
                  end else begin
                    phase         <= PH_HUNT;
                    byte_position <= '0;
                    tail_bytes    <= '0;
                    running_crc   <= mbp_pkg::CRC_INIT;
                  end
                end
                PH_DATA: begin
                  if (ram_we) begin
                    byte_position <= byte_position + POS_W'(1);
                    running_crc   <= running_crc ^ {8'h00, byte_stream.rx_byte};
                    seq           <= SQ_CRC;
                  end else if (frame_end) begin
                    phase         <= PH_HUNT;
                    byte_position <= '0;
                    tail_bytes    <= '0;
                    running_crc   <= mbp_pkg::CRC_INIT;
                    field_k       <= '0;
                    off           <= '0;
                    byte_cnt      <= '0;
                    acc           <= '0;
                    if (crc_check_enable && (tail_new != running_crc)) begin
                      err <= 1'b1;
                      seq <= SQ_OUT;
                    end else begin
                      err            <= 1'b0;
                      accepted_count <= accepted_count + 1'b1;
                      seq            <= SQ_FETCH;
                    end
                  end else begin
                    byte_position <= byte_position + POS_W'(1);
                    tail_bytes    <= tail_new;
                  end
                end
                PH_DISCARD: ;
                default: phase <= PH_HUNT;
              endcase
            end
          end
        end
        SQ_CRC: begin
          running_crc <= crc_step;
          bit_cnt     <= bit_cnt + 3'd1;
          if (bit_cnt == 3'd7) begin
            seq <= SQ_IDLE;
          end
        end
        SQ_FETCH: begin
          seq <= SQ_ACC;
        end
        SQ_ACC: begin
          acc <= {acc[mbp_pkg::FIELD_VALUE_W-9:0], rd_byte};
          off <= off + 1'b1;
          if (field_done) begin
            byte_cnt <= '0;
            seq      <= SQ_OUT;
          end else begin
            byte_cnt <= byte_cnt + 3'd1;
            seq      <= SQ_FETCH;
          end
        end
        SQ_OUT: begin
          if (out_free) begin
            if (is_last_field) begin
              seq <= SQ_IDLE;
            end else begin
              field_k <= field_k + 1'b1;
              acc     <= '0;
              seq     <= SQ_FETCH;
            end
          end
        end
        default: seq <= SQ_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/tb_modbus_bms_response_parser.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_bms_response_parser
// Self-checking bench for the Modbus BMS read-response parser.
// ----------------------------------------------------------------------------
// A queue of byte and gap items feeds a valid/ready driver. Every accepted
// item runs through a local frame parser that predicts the decoded fields.
// A monitor compares each result against the oldest prediction. Config is
// rewritten over APB between phases, and each phase turns sender gaps and
// receiver stalls on or off. The stimulus starts with directed frames
// and broken frames, then moves to random frames with noise mixed in.
// ----------------------------------------------------------------------------
module tb_modbus_bms_response_parser;
  import mbp_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 32;
  localparam int FULL_FRAME    = 1000;
  localparam int MAX_COUNT     = MAX_BYTE_COUNT_DEF;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_FUNC,
    ST_COUNT,
    ST_DATA,
    ST_DISCARD
  } parse_state_t;

  typedef struct {
    opcode_t                op;
    logic [RX_BYTE_W-1:0]   data;
    int                     gap;
    bit                     hold;
  } byte_item_t;

  typedef struct {
    logic [FIELD_INDEX_W-1:0]  field_index;
    logic [FIELD_VALUE_W-1:0]  field_value;
    logic                      frame_status;
    logic [GOOD_FRAMES_W-1:0]  good_frames;
    logic                      last;
  } field_result_t;

  logic clk = 1'b0;
  logic rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  mbp_byte_if  byte_bus ();
  mbp_field_if field_bus ();

  modbus_bms_response_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_stream  (byte_bus),
    .field_stream (field_bus),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_item_t     pending_bytes[$];
  field_result_t  fields_due[$];
  byte_item_t     cur_item;
  bit             offering = 1'b0;
  int             gap_count = 0;
  int             stall_left = 0;
  bit             src_idle = 1'b0;
  bit             sink_idle = 1'b0;
  bit             hold_next = 1'b0;
  int             queued = 0;
  int             fails = 0;
  int             cycle_count = 0;

  // local parser state and config copy
  logic [7:0]          cfg_addr = 8'd1;
  logic [7:0]          cfg_func = 8'd3;
  bit                  cfg_crc_on = 1'b0;
  parse_state_t        hunt_state = ST_HUNT;
  int                  byte_pos = 0;
  int                  frame_len = 0;
  logic [7:0]          frame_bytes[MAX_COUNT];
  logic [15:0]         frame_crc = CRC_INIT;
  logic [15:0]         crc_tail = 16'h0000;
  logic [GOOD_FRAMES_W-1:0] frames_ok = '0;

  function automatic logic [15:0] crc16_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    int i;
    c = crc ^ {8'h00, b};
    for (i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void restart_hunt();
    hunt_state = ST_HUNT;
    byte_pos = 0;
    crc_tail = 16'h0000;
    frame_crc = CRC_INIT;
  endfunction

  function automatic void parse_item(byte_item_t it);
    field_result_t r;
    logic [31:0] v;
    int off;
    int k;
    int j;
    int width;
    if (it.op == OP_GAP) begin
      restart_hunt();
      return;
    end
    case (hunt_state)
      ST_HUNT: begin
        if (it.data == cfg_addr) begin
          frame_crc = crc16_feed(CRC_INIT, it.data);
          byte_pos = 0;
          crc_tail = 16'h0000;
          hunt_state = ST_FUNC;
        end else begin
          hunt_state = ST_DISCARD;
        end
      end
      ST_FUNC: begin
        if (it.data == cfg_func) begin
          frame_crc = crc16_feed(frame_crc, it.data);
          hunt_state = ST_COUNT;
        end else begin
          hunt_state = ST_DISCARD;
        end
      end
      ST_COUNT: begin
        if (it.data <= MAX_COUNT) begin
          frame_crc = crc16_feed(frame_crc, it.data);
          frame_len = int'(it.data);
          byte_pos = 0;
          crc_tail = 16'h0000;
          hunt_state = ST_DATA;
        end else begin
          restart_hunt();
        end
      end
      ST_DATA: begin
        if (byte_pos < frame_len) begin
          frame_bytes[byte_pos] = it.data;
          frame_crc = crc16_feed(frame_crc, it.data);
        end else begin
          crc_tail = {it.data, crc_tail[15:8]};
        end
        byte_pos++;
        if (byte_pos >= frame_len + 2) begin
          if (cfg_crc_on && crc_tail != frame_crc) begin
            r = '{field_index: '0, field_value: '0, frame_status: 1'b1,
                  good_frames: frames_ok, last: 1'b1};
            fields_due.push_back(r);
          end else begin
            frames_ok++;
            off = 0;
            for (k = 0; k < NUM_FIELDS; k++) begin
              // pack mV, mA and the two capacities are 32-bit
              width = (k == CELL_COUNT || k == CELL_COUNT + 1 ||
                       k == CELL_COUNT + 2 + TEMP_COUNT ||
                       k == CELL_COUNT + 3 + TEMP_COUNT) ? 4 : 2;
              v = '0;
              for (j = 0; j < width; j++) begin
                if (off < frame_len && off < DECODED_BYTES)
                  v = {v[23:0], frame_bytes[off]};
                else
                  v = {v[23:0], 8'h00};
                off++;
              end
              r.field_index  = FIELD_INDEX_W'(k);
              r.field_value  = v;
              r.frame_status = 1'b0;
              r.good_frames  = frames_ok;
              r.last         = (k == NUM_FIELDS - 1);
              fields_due.push_back(r);
            end
          end
          restart_hunt();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      byte_bus.valid <= 1'b0;
      offering = 1'b0;
      gap_count = 0;
    end else begin
      if (byte_bus.valid && byte_bus.ready) begin
        parse_item(cur_item);
        offering = 1'b0;
      end
      if (!offering && pending_bytes.size() > 0) begin
        if (!(pending_bytes[0].hold && fields_due.size() > 0)) begin
          if (gap_count < pending_bytes[0].gap) begin
            gap_count++;
          end else begin
            cur_item = pending_bytes.pop_front();
            gap_count = 0;
            offering = 1'b1;
          end
        end
      end
      byte_bus.valid   <= offering;
      byte_bus.opcode  <= cur_item.op;
      byte_bus.rx_byte <= cur_item.data;
    end
  end

  // field monitor
  always @(posedge clk) begin
    field_result_t want;
    if (rst) begin
      field_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (field_bus.valid && field_bus.ready) begin
        if (fields_due.size() == 0) begin
          $error("field result with none expected: index %0d value %0h",
                 field_bus.field_index, field_bus.field_value);
          fails++;
        end else begin
          want = fields_due.pop_front();
          check_field("field_index", 32'(want.field_index),
                      32'(field_bus.field_index));
          check_field("field_value", want.field_value, field_bus.field_value);
          check_field("frame_status", 32'(want.frame_status),
                      32'(field_bus.frame_status));
          check_field("good_frames", 32'(want.good_frames),
                      32'(field_bus.good_frames));
          check_field("last", 32'(want.last), 32'(field_bus.last));
        end
        stall_left = sink_idle ? $urandom_range(0, 10) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        field_bus.ready <= 1'b0;
      end else begin
        field_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("modbus_bms_response_parser: mismatch");
    $finish;
  end

  task automatic push_item(opcode_t op, logic [7:0] data);
    byte_item_t it;
    it.op   = op;
    it.data = data;
    it.gap  = src_idle ? $urandom_range(0, 10) : 0;
    it.hold = hold_next;
    hold_next = 1'b0;
    pending_bytes.push_back(it);
    queued++;
  endtask

  task automatic push_frame(logic [7:0] addr, logic [7:0] func, int count,
                            bit bad_crc, bit ones, int cut);
    logic [7:0] bytes[$];
    logic [15:0] crc;
    int i;
    bytes.push_back(addr);
    bytes.push_back(func);
    bytes.push_back(8'(count));
    for (i = 0; i < count; i++) begin
      bytes.push_back(ones ? 8'hFF : 8'($urandom));
    end
    crc = CRC_INIT;
    foreach (bytes[n]) crc = crc16_feed(crc, bytes[n]);
    if (bad_crc) crc ^= 16'($urandom_range(1, 16'hFFFF));
    bytes.push_back(crc[7:0]);
    bytes.push_back(crc[15:8]);
    for (i = 0; i < bytes.size() && i < cut; i++) begin
      push_item(OP_BYTE, bytes[i]);
    end
  endtask

  task automatic apb_write(reg_index_t idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] addr, logic [7:0] func, bit crc_on,
                            bit src_i, bit sink_i);
    while (pending_bytes.size() != 0 || offering || fields_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_SLAVE_ADDRESS, {24'h0, addr});
    cfg_addr = addr;
    apb_write(REG_READ_FUNCTION_CODE, {24'h0, func});
    cfg_func = func;
    apb_write(REG_CRC_CHECK_ENABLE, {31'h0, crc_on});
    cfg_crc_on = crc_on;
    src_idle  = src_i;
    sink_idle = sink_i;
  endtask

  task automatic random_items(int n);
    int target;
    int pick;
    int count;
    int i;
    target = queued + n;
    while (queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        push_item(OP_GAP, 8'($urandom));
      end else if (pick < 16) begin
        push_item(opcode_t'($urandom_range(0, 1)), 8'($urandom));
      end else if (pick < 28) begin
        case ($urandom_range(0, 3))
          0: begin
            push_item(OP_BYTE, cfg_addr ^ 8'($urandom_range(1, 255)));
            for (i = $urandom_range(0, 3); i > 0; i--) push_item(OP_BYTE, 8'($urandom));
          end
          1: begin
            push_item(OP_BYTE, cfg_addr);
            push_item(OP_BYTE, cfg_func ^ 8'($urandom_range(1, 255)));
            for (i = $urandom_range(0, 3); i > 0; i--) push_item(OP_BYTE, 8'($urandom));
          end
          2: begin
            push_item(OP_BYTE, cfg_addr);
            push_item(OP_BYTE, cfg_func);
            push_item(OP_BYTE, 8'($urandom_range(MAX_COUNT + 1, 255)));
          end
          default: begin
            count = $urandom_range(0, 12);
            push_frame(cfg_addr, cfg_func, count, 1'b0, 1'b0,
                       $urandom_range(1, count + 4));
            push_item(OP_GAP, 8'($urandom));
          end
        endcase
      end else begin
        if ($urandom_range(0, 9) < 7) push_item(OP_GAP, 8'($urandom));
        count = ($urandom_range(0, 19) == 0) ? $urandom_range(60, MAX_COUNT)
                                             : $urandom_range(0, 12);
        push_frame(cfg_addr, cfg_func, count, $urandom_range(0, 4) == 0,
                   1'b0, FULL_FRAME);
        if ($urandom_range(0, 9) == 0) hold_next = 1'b1;
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    byte_bus.valid   = 1'b0;
    byte_bus.opcode  = OP_BYTE;
    byte_bus.rx_byte = '0;
    field_bus.ready  = 1'b0;
    cur_item         = '{op: OP_BYTE, data: '0, gap: 0, hold: 1'b0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty frames, bad crc, wrong address, wrong function,
    // oversized count, short payload
    set_config(8'd1, 8'd3, 1'b1, 1'b1, 1'b1);
    push_frame(8'd1, 8'd3, 0, 1'b0, 1'b0, FULL_FRAME);
    hold_next = 1'b1;
    push_frame(8'd1, 8'd3, 0, 1'b1, 1'b0, FULL_FRAME);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_BYTE, 8'h01);
    push_item(OP_GAP, 8'hFF);
    push_item(OP_BYTE, 8'h01);
    push_item(OP_BYTE, 8'h04);
    push_item(OP_GAP, 8'h00);
    push_item(OP_BYTE, 8'h01);
    push_item(OP_BYTE, 8'h03);
    push_item(OP_BYTE, 8'(MAX_COUNT + 1));
    push_frame(8'd1, 8'd3, 2, 1'b0, 1'b1, FULL_FRAME);

    set_config(8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    random_items(30);

    set_config(8'd255, 8'd255, 1'b1, 1'b1, 1'b0);
    push_frame(8'd255, 8'd255, MAX_COUNT, 1'b0, 1'b1, FULL_FRAME);
    random_items(30);

    set_config(8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), 1'b0, 1'b1);
    random_items(30);

    set_config(8'd1, 8'd3, 1'b0, 1'b1, 1'b1);
    random_items(30);

    while (pending_bytes.size() != 0 || offering || fields_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0 && fields_due.size() == 0)
      $display("modbus_bms_response_parser: match");
    else
      $display("modbus_bms_response_parser: mismatch");
    $finish;
  end

endmodule

/* sim.f */
rtl/mbp_pkg.sv
rtl/mbp_stream_if.sv
rtl/mbp_ram.sv
rtl/modbus_bms_response_parser.sv
tb/sv/tb_modbus_bms_response_parser.sv
